// ----- src/altu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altu_pkg
// Shared constants for the addressed level table: field widths, request
// codes, register map and reply header layout.
// ----------------------------------------------------------------------------
package altu_pkg;

  // Payload widths
  localparam int ADDR_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int SEL_W   = 5;

  // Configuration port
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  // Register word indexes (byte address / 4)
  localparam logic REG_NODE_SELECT = 1'b0;

  // Request codes
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Reply header: start hi, start lo, end hi, end lo
  localparam int HDR_BYTES = 4;

endpackage

// ----- src/addressed_level_table_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_level_table_update
// Per-node level table on a shared addressing bus. Set items inside the
// node's window update the table; a message that hit, or a status query in
// the window, streams a reply of window bounds followed by all levels.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------
//   in       | input     | in_valid / in_stall    | req_type, address,
//            |           |                        | level, last_of_message
//   out      | output    | out_valid / out_stall  | resp_byte, resp_last
//   apb      | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// A reply is 4+CHANNELS bytes (20 by default), sent one byte per cycle
// unless the output stalls, paced by the single read port of the level
// memory; input stalls during the reply. Reset is synchronous and clears
// the table through per-slot valid bits, so no clearing pass is needed.
// A stalled output holds the reply.
// ----------------------------------------------------------------------------
module addressed_level_table_update #(
  parameter int CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [altu_pkg::PADDR_W-1:0]      paddr,
  input  logic [altu_pkg::PDATA_W-1:0]      pwdata,
  output logic [altu_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [altu_pkg::ADDR_W-1:0]       address,
  input  logic [altu_pkg::LEVEL_W-1:0]      level,
  input  logic                              last_of_message,
  // Reply channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [altu_pkg::LEVEL_W-1:0]      resp_byte,
  output logic                              resp_last
);

  localparam int NBYTES = altu_pkg::HDR_BYTES + CHANNELS;
  localparam int IDXW   = $clog2(CHANNELS);
  localparam int CNTW   = $clog2(NBYTES);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_REPLY = 1'b1;

  logic                                state;
  logic                                state_next;
  logic [altu_pkg::SEL_W-1:0]          node_select;
  logic                                message_hit;
  logic                                message_stopped;
  logic [CNTW-1:0]                     cnt;
  logic [CNTW-1:0]                     cnt_next;

  logic [altu_pkg::LEVEL_W-1:0]        level_mem [CHANNELS];
  logic [CHANNELS-1:0]                 slot_valid;
  logic [altu_pkg::LEVEL_W-1:0]        rd_data;
  logic                                rd_valid;
  logic [IDXW-1:0]                     rd_slot;
  logic                                rd_en;

  logic [altu_pkg::ADDR_W-1:0]         win_start;
  logic [altu_pkg::ADDR_W-1:0]         win_end;
  logic                                in_win;
  logic [IDXW-1:0]                     wr_slot;
  logic                                in_accept;
  logic                                set_accept;
  logic                                wr_en;
  logic                                hit_now;
  logic                                start_reply;
  logic                                out_load;
  logic                                cfg_write;
  logic [altu_pkg::LEVEL_W-1:0]        byte_sel;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_select <= '0;
    end else if (cfg_write && paddr[2] == altu_pkg::REG_NODE_SELECT) begin
      node_select <= pwdata[altu_pkg::SEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == altu_pkg::REG_NODE_SELECT) begin
      prdata = altu_pkg::PDATA_W'(node_select);
    end
  end

  // Address window of this node
  assign win_start = altu_pkg::ADDR_W'(32'(node_select) * CHANNELS + 1);
  assign win_end   = win_start + altu_pkg::ADDR_W'(CHANNELS - 1);
  assign in_win    = (address >= win_start) && (address <= win_end);
  assign wr_slot   = IDXW'(address - win_start);

  // Request decode
  assign in_stall   = (state == ST_REPLY);
  assign in_accept  = in_valid && !in_stall;
  assign set_accept = in_accept && (req_type == altu_pkg::REQ_SET);
  assign wr_en      = set_accept && !message_stopped && (address != '0) && in_win;
  assign hit_now    = message_hit || wr_en;

  always_comb begin
    start_reply = 1'b0;
    if (in_accept) begin
      if (req_type == altu_pkg::REQ_QUERY) begin
        start_reply = in_win;
      end else begin
        start_reply = last_of_message && hit_now;
      end
    end
  end

  // Track the current set message
  always_ff @(posedge clk) begin
    if (rst) begin
      message_hit     <= 1'b0;
      message_stopped <= 1'b0;
    end else if (set_accept) begin
      if (last_of_message) begin
        message_hit     <= 1'b0;
        message_stopped <= 1'b0;
      end else begin
        message_hit <= hit_now;
        if (!message_stopped && address == '0) begin
          message_stopped <= 1'b1;
        end
      end
    end
  end

  // Reply sequencer: load one byte whenever the output register is free
  assign out_load = (state == ST_REPLY) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (start_reply) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_load) begin
          if (cnt == CNTW'(NBYTES - 1)) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + CNTW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Level memory: one write port, one registered read port addressed ahead
  // by the next byte count so read data lines up with the current count
  assign rd_en   = (cnt_next >= CNTW'(altu_pkg::HDR_BYTES));
  assign rd_slot = IDXW'(cnt_next - CNTW'(altu_pkg::HDR_BYTES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_mem[wr_slot] <= level;
    end
    if (rd_en) begin
      rd_data <= level_mem[rd_slot];
    end
  end

  // Valid bits stand in for clearing the table at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid[wr_slot] <= 1'b1;
      end
      rd_valid <= rd_en && slot_valid[rd_slot];
    end
  end

  // Select the reply byte for the current count
  always_comb begin
    priority if (cnt == CNTW'(0)) begin
      byte_sel = win_start[15:8];
    end else if (cnt == CNTW'(1)) begin
      byte_sel = win_start[7:0];
    end else if (cnt == CNTW'(2)) begin
      byte_sel = win_end[15:8];
    end else if (cnt == CNTW'(3)) begin
      byte_sel = win_end[7:0];
    end else begin
      byte_sel = rd_valid ? rd_data : '0;
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      resp_byte <= byte_sel;
      resp_last <= (cnt == CNTW'(NBYTES - 1));
    end
  end

endmodule

// ----- src/altu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altu_checker
// Port-level checks for the addressed level table, bound to the top level.
// ----------------------------------------------------------------------------
module altu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              req_type,
  input logic                              last_of_message,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [altu_pkg::LEVEL_W-1:0]      resp_byte,
  input logic                              resp_last
);

  // Hold a stalled reply byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(resp_byte) && $stable(resp_last))
    else $error("reply byte changed while stalled");

  // Keep input stalled while a reply is still in progress
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !resp_last |-> in_stall)
    else $error("input accepted in the middle of a reply");

  // Start a reply only in answer to an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("reply started without a request");

  // A set that does not end its message never replies
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == altu_pkg::REQ_SET && !last_of_message
    |=> !in_stall)
    else $error("reply started before end of message");

endmodule

bind addressed_level_table_update altu_checker u_altu_checker (.*);
